// ===== rtl/xyls_pkg.sv =====
// Shared types and constants for the XY vector line sampler.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package xyls_pkg;

  localparam int COORD_W   = 16;
  localparam int CNT_W     = 7;
  localparam int SCALE_W   = 15;
  localparam int DIV_STEPS = COORD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int PROD_W    = 2 * COORD_W;
  localparam int FRAC_BITS = 13;

  localparam logic [CNT_W-1:0]   RST_SAMPLES = 7'd16;
  localparam logic [SCALE_W-1:0] RST_X_SCALE = 15'd30000;
  localparam logic [SCALE_W-1:0] RST_Y_SCALE = 15'd16000;

  typedef enum logic [1:0] {
    REG_SAMPLES = 2'd0,
    REG_X_SCALE = 2'd1,
    REG_Y_SCALE = 2'd2
  } reg_index_t;

  // One segment after the front end: start point and per-sample step as
  // quotient and remainder of |end - start| by the sample count.
  typedef struct packed {
    logic signed [COORD_W-1:0] x_start;
    logic signed [COORD_W-1:0] y_start;
    logic [COORD_W-1:0]        x_quot;
    logic [COORD_W-1:0]        y_quot;
    logic [CNT_W-1:0]          x_rem;
    logic [CNT_W-1:0]          y_rem;
    logic                      x_neg;
    logic                      y_neg;
  } xyls_seg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } xyls_qstat_t;

endpackage

// ===== rtl/xy_vector_line_sampler.sv =====
// XY vector line sampler, top level. Depends on xyls_pkg, xyls_front,
// xyls_queue and xyls_back.
// Segment rate: set by the front end's 16-step divider and by the back end, which
// emits one sample a cycle while out_stall is low, N samples per segment, N the
// effective sample count.
// Reset: synchronous, clears all handshake state and loads register defaults.
`timescale 1ns / 1ps

module xy_vector_line_sampler import xyls_pkg::*; #(
  parameter int MAX_SAMPLES_PER_LINE = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [SCALE_W-1:0]        cfg_data,
  // segment input
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] x_start,
  input  logic signed [COORD_W-1:0] y_start,
  input  logic signed [COORD_W-1:0] x_end,
  input  logic signed [COORD_W-1:0] y_end,
  // sample output
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] x_sample,
  output logic signed [COORD_W-1:0] y_sample,
  output logic                      last_sample
);

  // Configuration registers; only written while the block is idle, a rule on the user not enforced here.
  logic [CNT_W-1:0]   run_length;
  logic [SCALE_W-1:0] x_scale;
  logic [SCALE_W-1:0] y_scale;
  logic [CNT_W-1:0]   samples_eff;

  xyls_seg_t   push_seg;
  xyls_seg_t   head;
  xyls_qstat_t qstat;
  logic        push;
  logic        pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length <= RST_SAMPLES;
      x_scale    <= RST_X_SCALE;
      y_scale    <= RST_Y_SCALE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SAMPLES: run_length <= cfg_data[CNT_W-1:0];
        REG_X_SCALE: x_scale    <= cfg_data;
        REG_Y_SCALE: y_scale    <= cfg_data;
        default:     ; // drop writes beyond the register list
      endcase
    end
  end

  // Clamp the sample count: zero runs as a single sample, large counts
  // saturate to the maximum run length.
  always_comb begin
    if (run_length == '0) begin
      samples_eff = CNT_W'(1);
    end else if (run_length > CNT_W'(MAX_SAMPLES_PER_LINE)) begin
      samples_eff = CNT_W'(MAX_SAMPLES_PER_LINE);
    end else begin
      samples_eff = run_length;
    end
  end

  // Front end: take a segment, work out start point and per-sample step.
  xyls_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .x_start  (x_start),
    .y_start  (y_start),
    .x_end    (x_end),
    .y_end    (y_end),
    .samples  (samples_eff),
    .qstat    (qstat),
    .push     (push),
    .push_seg (push_seg)
  );

  // Hold up to two prepared segments so either side may stall alone.
  xyls_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_seg (push_seg),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  // Back end: advance the run one sample a cycle while the output is not stalled, scale, saturate, register.
  xyls_back #(
    .MAX_SAMPLES_PER_LINE (MAX_SAMPLES_PER_LINE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .samples     (samples_eff),
    .x_scale     (x_scale),
    .y_scale     (y_scale),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .x_sample    (x_sample),
    .y_sample    (y_sample),
    .last_sample (last_sample)
  );

  // The front end works on one item at a time: after an accept it stalls.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("front end accepted back-to-back items");

  // No sample comes out in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("sample valid right after reset");

  // Queue status flags are never both set.
  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty at once");

  // A pop only happens with a segment waiting.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

endmodule

// ===== rtl/xyls_front.sv =====
// Front end: accepts a segment and divides |end - start| by the sample count.
// Depends on xyls_pkg; feeds xyls_queue.
`timescale 1ns / 1ps

module xyls_front import xyls_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] x_start,
  input  logic signed [COORD_W-1:0] y_start,
  input  logic signed [COORD_W-1:0] x_end,
  input  logic signed [COORD_W-1:0] y_end,
  input  logic [CNT_W-1:0]          samples,
  input  xyls_qstat_t               qstat,
  output logic                      push,
  output xyls_seg_t                 push_seg
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t              state;
  logic [STEP_W-1:0]         step;
  logic signed [COORD_W-1:0] x_start_r;
  logic signed [COORD_W-1:0] y_start_r;
  logic [COORD_W-1:0]        x_dvd;
  logic [COORD_W-1:0]        y_dvd;
  logic [CNT_W-1:0]          x_rem;
  logic [CNT_W-1:0]          y_rem;
  logic                      x_neg;
  logic                      y_neg;

  logic signed [COORD_W:0] x_diff;
  logic signed [COORD_W:0] y_diff;
  logic [COORD_W:0]        x_mag;
  logic [COORD_W:0]        y_mag;
  logic [CNT_W:0]          x_trial;
  logic [CNT_W:0]          y_trial;
  logic [CNT_W:0]          x_sub;
  logic [CNT_W:0]          y_sub;
  logic                    x_ge;
  logic                    y_ge;
  logic [CNT_W-1:0]        x_rem_next;
  logic [CNT_W-1:0]        y_rem_next;

  always_comb begin
    x_diff = {x_end[COORD_W-1], x_end} - {x_start[COORD_W-1], x_start};
    y_diff = {y_end[COORD_W-1], y_end} - {y_start[COORD_W-1], y_start};
    x_mag  = x_diff[COORD_W] ? -x_diff : x_diff;
    y_mag  = y_diff[COORD_W] ? -y_diff : y_diff;
  end

  // one restoring division step per cycle on each axis
  always_comb begin
    x_trial    = {x_rem, x_dvd[COORD_W-1]};
    y_trial    = {y_rem, y_dvd[COORD_W-1]};
    x_sub      = x_trial - {1'b0, samples};
    y_sub      = y_trial - {1'b0, samples};
    x_ge       = x_trial >= {1'b0, samples};
    y_ge       = y_trial >= {1'b0, samples};
    x_rem_next = x_ge ? x_sub[CNT_W-1:0] : x_trial[CNT_W-1:0];
    y_rem_next = y_ge ? y_sub[CNT_W-1:0] : y_trial[CNT_W-1:0];
  end

  assign in_stall = (state != F_IDLE);
  assign push     = (state == F_PUSH) && !qstat.full;

  always_comb begin
    push_seg.x_start = x_start_r;
    push_seg.y_start = y_start_r;
    push_seg.x_quot  = x_dvd;
    push_seg.y_quot  = y_dvd;
    push_seg.x_rem   = x_rem;
    push_seg.y_rem   = y_rem;
    push_seg.x_neg   = x_neg;
    push_seg.y_neg   = y_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            state <= F_DIV;
            step  <= '0;
          end
        end
        F_DIV: begin
          step <= step + 1'b1;
          if (step == STEP_W'(DIV_STEPS - 1)) state <= F_PUSH;
        end
        F_PUSH: begin
          if (!qstat.full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid) begin
      x_start_r <= x_start;
      y_start_r <= y_start;
      x_dvd     <= x_mag[COORD_W-1:0];
      y_dvd     <= y_mag[COORD_W-1:0];
      x_rem     <= '0;
      y_rem     <= '0;
      x_neg     <= x_diff[COORD_W];
      y_neg     <= y_diff[COORD_W];
    end else if (state == F_DIV) begin
      x_dvd <= {x_dvd[COORD_W-2:0], x_ge};
      y_dvd <= {y_dvd[COORD_W-2:0], y_ge};
      x_rem <= x_rem_next;
      y_rem <= y_rem_next;
    end
  end

endmodule

// ===== rtl/xyls_queue.sv =====
// Two-entry segment queue between the front end and the sample generator.
// Depends on xyls_pkg.
`timescale 1ns / 1ps

module xyls_queue import xyls_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  xyls_seg_t   push_seg,
  input  logic        pop,
  output xyls_seg_t   head,
  output xyls_qstat_t qstat
);

  xyls_seg_t  ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign qstat.full  = (count == 2'd2);
  assign qstat.empty = (count == 2'd0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent[wr_ptr] <= push_seg;
  end

endmodule

// ===== rtl/xyls_back.sv =====
// Back end: steps through the samples of a segment, scales and saturates them.
// Depends on xyls_pkg; takes segments from xyls_queue.
`timescale 1ns / 1ps

module xyls_back import xyls_pkg::*; #(
  parameter int MAX_SAMPLES_PER_LINE = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  xyls_seg_t                 head,
  input  xyls_qstat_t               qstat,
  output logic                      pop,
  input  logic [CNT_W-1:0]          samples,
  input  logic [SCALE_W-1:0]        x_scale,
  input  logic [SCALE_W-1:0]        y_scale,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] x_sample,
  output logic signed [COORD_W-1:0] y_sample,
  output logic                      last_sample
);

  localparam int IDX_W = (MAX_SAMPLES_PER_LINE > 1) ? $clog2(MAX_SAMPLES_PER_LINE) : 1;

  function automatic logic signed [COORD_W-1:0] scale_sat(
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [PROD_W-1:0] adj;
    logic signed [PROD_W-1:0] shr;
    logic signed [COORD_W-1:0] res;
    adj = prod + (prod[PROD_W-1] ? PROD_W'((1 << FRAC_BITS) - 1) : '0);
    shr = adj >>> FRAC_BITS;
    if (shr > PROD_W'(32767)) begin
      res = 16'sh7fff;
    end else if (shr < -PROD_W'(32768)) begin
      res = 16'sh8000;
    end else begin
      res = shr[COORD_W-1:0];
    end
    return res;
  endfunction

  logic             active;
  xyls_seg_t        seg;
  logic [COORD_W-1:0] xq;
  logic [COORD_W-1:0] yq;
  logic [CNT_W-1:0] xr;
  logic [CNT_W-1:0] yr;
  logic [IDX_W-1:0] idx;

  logic                      a_valid;
  logic                      a_last;
  logic signed [COORD_W-1:0] a_x;
  logic signed [COORD_W-1:0] a_y;
  logic                      b_valid;
  logic                      b_last;
  logic signed [PROD_W-1:0]  b_x;
  logic signed [PROD_W-1:0]  b_y;

  logic                      adv;
  logic                      is_last;
  logic signed [COORD_W:0]   x_off;
  logic signed [COORD_W:0]   y_off;
  logic signed [COORD_W:0]   x_pos;
  logic signed [COORD_W:0]   y_pos;
  logic [CNT_W:0]            x_rsum;
  logic [CNT_W:0]            y_rsum;
  logic [CNT_W:0]            x_rsub;
  logic [CNT_W:0]            y_rsub;
  logic                      x_wrap;
  logic                      y_wrap;

  assign adv     = !out_valid || !out_stall;
  assign pop     = !active && !qstat.empty;
  assign is_last = (CNT_W'(idx) == samples - CNT_W'(1));

  always_comb begin
    x_off  = seg.x_neg ? -$signed({1'b0, xq}) : $signed({1'b0, xq});
    y_off  = seg.y_neg ? -$signed({1'b0, yq}) : $signed({1'b0, yq});
    x_pos  = $signed({seg.x_start[COORD_W-1], seg.x_start}) + x_off;
    y_pos  = $signed({seg.y_start[COORD_W-1], seg.y_start}) + y_off;
    x_rsum = {1'b0, xr} + {1'b0, seg.x_rem};
    y_rsum = {1'b0, yr} + {1'b0, seg.y_rem};
    x_rsub = x_rsum - {1'b0, samples};
    y_rsub = y_rsum - {1'b0, samples};
    x_wrap = x_rsum >= {1'b0, samples};
    y_wrap = y_rsum >= {1'b0, samples};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b1;
      end else if (adv && active && is_last) begin
        active <= 1'b0;
      end
      if (adv) begin
        a_valid   <= active;
        b_valid   <= a_valid;
        out_valid <= b_valid;
      end
    end
  end

  // step state and datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      seg <= head;
      xq  <= '0;
      yq  <= '0;
      xr  <= '0;
      yr  <= '0;
      idx <= '0;
    end else if (adv && active) begin
      xq  <= xq + seg.x_quot + COORD_W'(x_wrap);
      yq  <= yq + seg.y_quot + COORD_W'(y_wrap);
      xr  <= x_wrap ? x_rsub[CNT_W-1:0] : x_rsum[CNT_W-1:0];
      yr  <= y_wrap ? y_rsub[CNT_W-1:0] : y_rsum[CNT_W-1:0];
      idx <= idx + 1'b1;
    end
    if (adv) begin
      a_x         <= x_pos[COORD_W-1:0];
      a_y         <= y_pos[COORD_W-1:0];
      a_last      <= is_last;
      b_x         <= a_x * $signed({1'b0, x_scale});
      b_y         <= a_y * $signed({1'b0, y_scale});
      b_last      <= a_last;
      x_sample    <= scale_sat(b_x);
      y_sample    <= scale_sat(b_y);
      last_sample <= b_last;
    end
  end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the XY vector line sampler: line segments in,
// deflection sample runs out, checked against an in-bench predictor.
// Depends on xyls_pkg and xy_vector_line_sampler.
`timescale 1ns / 1ps

module tb;
  import xyls_pkg::*;

  // Index with no register behind it: writes to it must change nothing.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int     MAX_SAMPLES     = 64;
  localparam longint Q13_ONE         = 8192;
  localparam longint SAMPLE_MAX      = 32767;
  localparam longint SAMPLE_MIN      = -32768;
  localparam int     RANDOM_PHASES   = 8;
  localparam int     ITEMS_PER_PHASE = 37;
  // Settle time for the pipe once every predicted sample has drained.
  localparam int     SETTLE_CYCLES   = 45;
  localparam int     REPORT_LIMIT    = 10;
  // Watchdog bound, well above the slowest correct run: ~310 items of up to 64
  // samples each under heavy stalling, plus gaps and drains.
  localparam int     CYCLE_LIMIT     = 1_000_000;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } sample_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_write;
  logic [1:0]                cfg_index;
  logic [SCALE_W-1:0]        cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [COORD_W-1:0] x_start;
  logic signed [COORD_W-1:0] y_start;
  logic signed [COORD_W-1:0] x_end;
  logic signed [COORD_W-1:0] y_end;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COORD_W-1:0] x_sample;
  logic signed [COORD_W-1:0] y_sample;
  logic                      last_sample;

  // Predictor's copy of the register file.
  logic [CNT_W-1:0]   line_samples;
  logic [SCALE_W-1:0] x_gain;
  logic [SCALE_W-1:0] y_gain;

  sample_t     expected_samples[$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          pace_sender = 1'b1;
  int          burst_left  = 0;
  stall_mode_t stall_mode  = STALL_NONE;
  int          mode_left   = 0;

  xy_vector_line_sampler uut (.*);

  always #5 clk = ~clk;

  // Watchdog: fail the run once cycle_count reaches CYCLE_LIMIT, as when the block stops moving.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples outstanding", cycle_count,
               expected_samples.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver back-pressure. Switch between free running, light and heavy
  // random stalling and a fixed duty pattern at random intervals, so
  // stalls land on every phase of a run and some stretches see none at all.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      mode_left <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(50, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= (cycle_count[2:0] < 3'd2);
      endcase
    end
  end

  // Sample checker: every accepted sample must match the oldest prediction.
  // Values are read just after the edge, so they are the ones the edge saw.
  always @(posedge clk) begin
    sample_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected sample x=%0d y=%0d last=%0b at %0t",
                   x_sample, y_sample, last_sample, $realtime);
      end else begin
        want = expected_samples.pop_front();
        if (want.x !== x_sample || want.y !== y_sample || want.last !== last_sample) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("sample mismatch at %0t: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     $realtime, want.x, want.y, want.last, x_sample, y_sample, last_sample);
        end
      end
    end
  end

  // Scale one axis position: multiply, drop 13 fraction bits rounding toward
  // zero (SystemVerilog signed division already does), then clamp to 16 bits.
  function automatic logic signed [COORD_W-1:0] deflection(int pos, int gain);
    longint scaled;
    scaled = (longint'(pos) * longint'(gain)) / Q13_ONE;
    if (scaled > SAMPLE_MAX) scaled = SAMPLE_MAX;
    else if (scaled < SAMPLE_MIN) scaled = SAMPLE_MIN;
    return scaled[COORD_W-1:0];
  endfunction

  // Work out the whole run of one segment. A count of zero draws a single
  // sample at the start point; counts above 64 are held at 64. The endpoint
  // itself is part of the run only where it equals the start point.
  function automatic void predict_segment_run(logic signed [COORD_W-1:0] xs, ys, xe, ye);
    int      run_len;
    int      x_span;
    int      y_span;
    sample_t s;
    run_len = int'(line_samples);
    if (run_len < 1) run_len = 1;
    if (run_len > MAX_SAMPLES) run_len = MAX_SAMPLES;
    x_span = int'(xe) - int'(xs);
    y_span = int'(ye) - int'(ys);
    for (int i = 0; i < run_len; i++) begin
      s.x    = deflection(int'(xs) + (x_span * i) / run_len, int'(x_gain));
      s.y    = deflection(int'(ys) + (y_span * i) / run_len, int'(y_gain));
      s.last = (i == run_len - 1);
      expected_samples.push_back(s);
    end
  endfunction

  // Offer one segment and hold it until taken. The sender runs in bursts of
  // random length with random gaps between them while pacing is on; valid
  // stays high between back-to-back items so no edge is wasted.
  task automatic send_segment(input logic signed [COORD_W-1:0] xs, ys, xe, ye);
    int gap;
    gap = 0;
    if (pace_sender) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(1, 10);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    x_start  <= xs;
    y_start  <= ys;
    x_end    <= xe;
    y_end    <= ye;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_segment_run(xs, ys, xe, ye);
  endtask

  // Drop valid, let every predicted sample drain, then let the pipe settle.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register and track it in the predictor; unknown indexes are
  // ignored by the block, so ignore them here too.
  task automatic write_reg(input logic [1:0] idx, input logic [SCALE_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SAMPLES: line_samples = data[CNT_W-1:0];
      REG_X_SCALE: x_gain = data;
      REG_Y_SCALE: y_gain = data;
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] corner_coord();
    case ($urandom_range(0, 4))
      0:       return 16'sh8000;
      1:       return 16'shFFFF;
      2:       return 16'sh0000;
      3:       return 16'sh0001;
      default: return 16'sh7FFF;
    endcase
  endfunction

  // Reset values of the registers: sixteen samples, default scales.
  task automatic test_reset_defaults();
    send_segment(16'sh0000, 16'sh0000, 16'sh2000, -16'sh2000);
    send_segment(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
  endtask

  // Sample count limits: zero, one, the maximum, above it, and a count that
  // does not divide the span so negative quotients must truncate toward zero.
  task automatic test_sample_count_limits();
    wait_for_idle();
    write_reg(REG_SAMPLES, 15'h7F80);   // low seven bits zero: one sample
    send_segment(16'sh1000, -16'sh1000, -16'sh1000, 16'sh1000);
    wait_for_idle();
    write_reg(REG_SAMPLES, 15'd1);
    send_segment(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    wait_for_idle();
    write_reg(REG_SAMPLES, 15'h7FFF);   // 127, held at 64
    send_segment(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
    wait_for_idle();
    write_reg(REG_SAMPLES, 15'd65);
    send_segment(16'sd100, -16'sd100, -16'sd100, 16'sd100);
    wait_for_idle();
    write_reg(REG_SAMPLES, 15'd64);
    send_segment(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    wait_for_idle();
    write_reg(REG_SAMPLES, 15'd3);
    send_segment(16'sd0, 16'sd0, -16'sd7, 16'sd7);
    send_segment(16'sd5, -16'sd5, -16'sd3, 16'sd3);
  endtask

  // Scale extremes: full scale drives both saturation limits, zero scale
  // flattens an axis, unit scale checks small negatives truncate to zero.
  task automatic test_scale_saturation();
    wait_for_idle();
    write_reg(REG_SAMPLES, 15'd2);
    write_reg(REG_X_SCALE, 15'h7FFF);
    write_reg(REG_Y_SCALE, 15'd0);
    send_segment(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
    send_segment(16'sh8000, 16'sh0000, 16'sh8000, 16'sh0000);
    wait_for_idle();
    write_reg(REG_X_SCALE, 15'd0);
    write_reg(REG_Y_SCALE, 15'h7FFF);
    send_segment(16'sd1234, 16'sh8000, -16'sd1234, 16'sh7FFF);
    wait_for_idle();
    write_reg(REG_X_SCALE, 15'd1);
    write_reg(REG_Y_SCALE, 15'd1);
    send_segment(-16'sd1, -16'sd8191, -16'sd8193, 16'sd8191);
  endtask

  // A write to the index past the register list must leave all settings alone.
  task automatic test_unused_register();
    wait_for_idle();
    write_reg(REG_SAMPLES, 15'd4);
    write_reg(REG_X_SCALE, 15'd30000);
    write_reg(REG_Y_SCALE, 15'd20000);
    write_reg(REG_UNUSED, 15'h0001);
    send_segment(16'sh4000, -16'sh4000, -16'sh6000, 16'sh3000);
  endtask

  // Random phases, each with fresh settings written while idle. Counts are
  // mostly small to keep the run short, with the odd long or out-of-range one.
  task automatic test_random_segments();
    logic signed [COORD_W-1:0] xs, ys, xe, ye;
    logic [31:0]               rnd;
    int                        count;
    int                        pick;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_idle();
      rnd  = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 70) count = $urandom_range(1, 8);
      else if (pick < 90) count = $urandom_range(9, 64);
      else if (pick < 95) count = $urandom_range(65, 127);
      else count = 0;
      write_reg(REG_SAMPLES, {rnd[7:0], 7'(count)});
      for (int axis = 0; axis < 2; axis++) begin
        pick = $urandom_range(0, 9);
        rnd  = (pick < 2) ? 32'd0 : (pick < 4) ? 32'h7FFF : $urandom;
        write_reg(axis == 0 ? REG_X_SCALE : REG_Y_SCALE, rnd[SCALE_W-1:0]);
      end
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 15'($urandom));
      // Leave the sender unpaced now and then for stretches of full rate.
      pace_sender = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          xs = 16'($urandom);
          ys = 16'($urandom);
          xe = 16'($urandom);
          ye = 16'($urandom);
        end else if (pick < 8) begin
          // short segment: end a few steps from start
          xs = 16'($urandom);
          ys = 16'($urandom);
          xe = xs + 16'($urandom_range(0, 64) - 32);
          ye = ys + 16'($urandom_range(0, 64) - 32);
        end else if (pick < 9) begin
          xs = corner_coord();
          ys = corner_coord();
          xe = corner_coord();
          ye = corner_coord();
        end else begin
          // degenerate segment: a single point
          xs = 16'($urandom);
          ys = 16'($urandom);
          xe = xs;
          ye = ys;
        end
        send_segment(xs, ys, xe, ye);
      end
    end
    pace_sender = 1'b1;
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_SAMPLES;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    x_start   <= '0;
    y_start   <= '0;
    x_end     <= '0;
    y_end     <= '0;
    repeat (4) @(posedge clk);
    rst          <= 1'b0;
    line_samples = RST_SAMPLES;
    x_gain       = RST_X_SCALE;
    y_gain       = RST_Y_SCALE;

    test_reset_defaults();
    test_sample_count_limits();
    test_scale_saturation();
    test_unused_register();
    test_random_segments();

    // Hold off until every sample has arrived, then allow for stragglers.
    wait_for_idle();
    if (error_count == 0 && expected_samples.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== xy_vector_line_sampler.f =====
rtl/xyls_pkg.sv
rtl/xyls_front.sv
rtl/xyls_queue.sv
rtl/xyls_back.sv
rtl/xy_vector_line_sampler.sv
tb/tb.sv
